>>> src/guwf_pkg.sv
// Shared constants, types and the id hash for the unique window filter.
`default_nettype none
package guwf_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SEEN_DEPTH = 2048;

    localparam int SLOT_W   = $clog2(MAX_SLOTS);
    localparam int SEEN_AW  = $clog2(SEEN_DEPTH);
    localparam int TIME_W   = 64;
    localparam int GID_HI_W = 32;
    localparam int GID_LO_W = 64;
    localparam int GID_W    = GID_HI_W + GID_LO_W;
    localparam int EPOCH_W  = 8;

    localparam int IN_IDX_LSB  = 0;
    localparam int IN_TIME_LSB = IN_IDX_LSB + SLOT_W;
    localparam int IN_HI_LSB   = IN_TIME_LSB + TIME_W;
    localparam int IN_LO_LSB   = IN_HI_LSB + GID_HI_W;
    localparam int IN_USED_W   = IN_LO_LSB + GID_LO_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = ((SLOT_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    localparam int TUSER_FIRST   = 0;
    localparam int TUSER_REMOVED = 1;
    localparam int TUSER_ACCEPT  = 0;
    localparam int TUSER_OVF     = 1;

    localparam int CFG_DW = 64;
    localparam int CFG_AW = 5;

    localparam logic [1:0] REG_UNIQUE_MODE  = 2'd0;
    localparam logic [1:0] REG_PASS_REMOVED = 2'd1;
    localparam logic [1:0] REG_WINDOW_START = 2'd2;
    localparam logic [1:0] REG_WINDOW_END   = 2'd3;

    typedef struct packed {
        logic              unique_mode;
        logic              pass_removed;
        logic [TIME_W-1:0] window_start;
        logic [TIME_W-1:0] window_end;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic clear_done;
        logic probe_start;
        logic probe_read;
        logic probe_next;
        logic insert;
        logic mark_found;
        logic mark_ovf;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic first;
        logic epoch_wrap;
        logic sweep_last;
        logic need_probe;
        logic empty_hit;
        logic match_hit;
        logic probe_last;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [GID_W-1:0]   gid;
    } seen_entry_t;

    function automatic logic [SEEN_AW-1:0] gid_hash(input logic [GID_W-1:0] gid);
        logic [SEEN_AW-1:0] h;
        h = '0;
        for (int i = 0; i < GID_W; i++)
        begin
            h[i % SEEN_AW] = h[i % SEEN_AW] ^ gid[i];
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> src/guwf_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module guwf_regs
    import guwf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic              unique_mode_reg;
    logic              pass_removed_reg;
    logic [TIME_W-1:0] window_start_reg;
    logic [TIME_W-1:0] window_end_reg;
    logic [1:0]        reg_sel;
    logic              wr_en;

    assign reg_sel = paddr[CFG_AW-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unique_mode_reg  <= 1'b1;
            pass_removed_reg <= 1'b0;
            window_start_reg <= '0;
            window_end_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_UNIQUE_MODE:  unique_mode_reg  <= pwdata[0];
                REG_PASS_REMOVED: pass_removed_reg <= pwdata[0];
                REG_WINDOW_START: window_start_reg <= pwdata[TIME_W-1:0];
                REG_WINDOW_END:   window_end_reg   <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:0] == 3'd0)
        begin
            unique case (reg_sel)
                REG_UNIQUE_MODE:  prdata = CFG_DW'(unique_mode_reg);
                REG_PASS_REMOVED: prdata = CFG_DW'(pass_removed_reg);
                REG_WINDOW_START: prdata = CFG_DW'(window_start_reg);
                REG_WINDOW_END:   prdata = CFG_DW'(window_end_reg);
                default:          prdata = '0;
            endcase
        end
    end

    assign cfg.unique_mode  = unique_mode_reg;
    assign cfg.pass_removed = pass_removed_reg;
    assign cfg.window_start = window_start_reg;
    assign cfg.window_end   = window_end_reg;

endmodule
`default_nettype wire

>>> src/guwf_ctrl.sv
// Controller state machine: clearing sweep, window check, hash probe and result handoff.
`default_nettype none
module guwf_ctrl
    import guwf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [2:0] S_CLR_BOOT = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CLR_ITEM = 3'd2;
    localparam logic [2:0] S_JUDGE    = 3'd3;
    localparam logic [2:0] S_PROBE    = 3'd4;
    localparam logic [2:0] S_CHECK    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_CLR_BOOT:
            begin
                cmd.clear = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.clear_done = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (stat.first && stat.epoch_wrap)
                    begin
                        state_next = S_CLR_ITEM;
                    end
                    else
                    begin
                        state_next = S_JUDGE;
                    end
                end
            end
            S_CLR_ITEM:
            begin
                cmd.clear = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.clear_done = 1'b1;
                    state_next     = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                if (stat.need_probe)
                begin
                    cmd.probe_start = 1'b1;
                    state_next      = S_CHECK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                cmd.probe_read = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.empty_hit)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.match_hit)
                begin
                    cmd.mark_found = 1'b1;
                    state_next     = S_DONE;
                end
                else if (stat.probe_last)
                begin
                    cmd.mark_ovf = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR_BOOT;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> src/guwf_dp.sv
// Datapath: item register, window compare, epoch-tagged hash table of seen ids, output register.
`default_nettype none
module guwf_dp
    import guwf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire dp_cmd_t                cmd,
    output dp_stat_t                    stat,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

    seen_entry_t seen_mem [SEEN_DEPTH];

    logic [SLOT_W-1:0]  slot_idx_reg;
    logic [TIME_W-1:0]  slot_time_reg;
    logic [GID_W-1:0]   gid_reg;
    logic               removed_reg;
    logic               found_reg;
    logic               ovf_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [SEEN_AW-1:0] sweep_reg;
    logic [SEEN_AW-1:0] probe_addr_reg;
    logic [SEEN_AW-1:0] probe_cnt_reg;
    seen_entry_t        rdata_reg;
    logic               out_valid_reg;
    logic [SLOT_W-1:0]  out_idx_reg;
    logic               out_accept_reg;
    logic               out_ovf_reg;

    logic               in_window;
    logic [SEEN_AW-1:0] hash;
    logic [SEEN_AW-1:0] rd_addr;
    logic [SEEN_AW-1:0] probe_addr_next;
    logic               out_free;

    assign in_window =
        ((cfg.window_start == '0) || (slot_time_reg >= cfg.window_start)) &&
        ((cfg.window_end == '0) || (slot_time_reg <= cfg.window_end));
    assign hash     = gid_hash(gid_reg);
    assign rd_addr  = cmd.probe_start ? hash : probe_addr_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign probe_addr_next = (probe_addr_reg == SEEN_AW'(SEEN_DEPTH - 1)) ?
                             '0 : probe_addr_reg + 1'b1;

    assign stat.first      = s_axis_tuser[TUSER_FIRST];
    assign stat.epoch_wrap = &epoch_reg;
    assign stat.sweep_last = (sweep_reg == SEEN_AW'(SEEN_DEPTH - 1));
    assign stat.need_probe = in_window && cfg.unique_mode;
    assign stat.empty_hit  = (rdata_reg.tag != epoch_reg);
    assign stat.match_hit  = (rdata_reg.gid == gid_reg);
    assign stat.probe_last = (probe_cnt_reg == SEEN_AW'(SEEN_DEPTH - 1));
    assign stat.out_free   = out_free;

    // Hold the item, its probe position and results, and load the output register on finish.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_idx_reg  <= s_axis_tdata[IN_IDX_LSB +: SLOT_W];
            slot_time_reg <= s_axis_tdata[IN_TIME_LSB +: TIME_W];
            gid_reg       <= {s_axis_tdata[IN_HI_LSB +: GID_HI_W],
                              s_axis_tdata[IN_LO_LSB +: GID_LO_W]};
            removed_reg   <= s_axis_tuser[TUSER_REMOVED];
            found_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.mark_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.mark_ovf)
            begin
                ovf_reg <= 1'b1;
            end
        end
        if (cmd.probe_start)
        begin
            probe_addr_reg <= hash;
            probe_cnt_reg  <= '0;
        end
        else if (cmd.probe_next)
        begin
            probe_addr_reg <= probe_addr_next;
            probe_cnt_reg  <= probe_cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            out_idx_reg    <= slot_idx_reg;
            out_accept_reg <= in_window && !found_reg &&
                              (!removed_reg || cfg.pass_removed);
            out_ovf_reg    <= ovf_reg;
        end
    end

    // Advance the epoch on a new file; sweep the table at reset and on epoch wrap; track out valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_done)
            begin
                epoch_reg <= EPOCH_W'(1);
                sweep_reg <= '0;
            end
            else
            begin
                if (cmd.load && s_axis_tuser[TUSER_FIRST])
                begin
                    epoch_reg <= epoch_reg + 1'b1;
                end
                if (cmd.clear)
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            seen_mem[sweep_reg] <= '0;
        end
        else if (cmd.insert)
        begin
            seen_mem[probe_addr_reg] <= {epoch_reg, gid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_start || cmd.probe_read)
        begin
            rdata_reg <= seen_mem[rd_addr];
        end
    end

    assign m_axis_tvalid                = out_valid_reg;
    assign m_axis_tdata                 = OUT_TDATA_W'(out_idx_reg);
    assign m_axis_tuser[TUSER_ACCEPT]   = out_accept_reg;
    assign m_axis_tuser[TUSER_OVF]      = out_ovf_reg;

endmodule
`default_nettype wire

>>> src/gid_unique_window_filter_unit.sv
// Top level of the unique window filter: registers, controller and datapath.
// Each item steps through accept, window check and hash read, table compare, output load;
// the read and compare are skipped when the window or the mode skips the probe, each further
// probe of the open-addressed seen table adds a read and a compare, up to SEEN_DEPTH probes
// when full, and the output load waits until the output register is free. One item is in
// flight at a time. Reset clears all control state, then a sweep clears the table tags;
// the same sweep runs again on every 255th new file.
`default_nettype none
module gid_unique_window_filter_unit
    import guwf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [CFG_DW-1:0]      pwdata,
    output logic      [CFG_DW-1:0]      prdata,
    output logic                        pready,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // slot_index, slot_time, gid_upper, gid_lower, zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // first_in_file, is_removed
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // slot_index_out, zero pad
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    // accept, seen_overflow
    output logic      [OUT_TUSER_W-1:0] m_axis_tuser
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    guwf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    guwf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    guwf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
`default_nettype wire
